FILE: hw/rtl/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types and constants for the frame receiver: controller states,
// checksum commands, configuration register indexes and the command and
// status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package frc_pkg;

    // frame start markers
    localparam logic [7:0] START_FIRST  = 8'hB1;
    localparam logic [7:0] START_SECOND = 8'h75;

    // one past the widest payload the result fields can describe
    localparam logic [6:0] MAX_PAYLOAD = 7'd64;

    // width of payload counters and result length fields
    localparam int CNT_W = 6;

    // configuration register indexes
    typedef enum logic {
        CFG_LENGTH_LIMIT  = 1'b0,
        CFG_CHANNEL_LIMIT = 1'b1
    } t_cfg_reg;

    // controller states
    typedef enum logic [3:0] {
        ST_START1,
        ST_START2,
        ST_ID1,
        ST_ID2,
        ST_CHAN,
        ST_LEN1,
        ST_LEN2,
        ST_DATA,
        ST_CHK1,
        ST_CHK2,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    // checksum accumulator operations
    typedef enum logic [1:0] {
        SUM_HOLD,
        SUM_CLEAR,
        SUM_ADD,
        SUM_SEED
    } t_sum_op;

    // controller to datapath commands
    typedef struct packed {
        t_sum_op sum_op;
        logic    load_id_hi;
        logic    load_id_lo;
        logic    load_chan;
        logic    load_len_hi;
        logic    load_len_lo;
        logic    cnt_clear;
        logic    store_byte;
        logic    load_chk;
        logic    rd_clear;
        logic    rd_issue;
        logic    rd_next;
        logic    out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_start1;
        logic is_start2;
        logic chan_ok;
        logic len_ok;
        logic len_zero;
        logic data_done;
        logic check_good;
        logic emit_last;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: hw/rtl/frc_ctrl.sv
// ----------------------------------------------------------------------------
// frc_ctrl
// Frame parsing state machine. Steps through the frame fields one received
// item at a time, restarts the search on bad fields, and sequences the
// payload read-out after a good checksum.
// ----------------------------------------------------------------------------
module frc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  frc_pkg::t_dp_sts i_sts,
    output frc_pkg::t_dp_cmd o_cmd
);
    import frc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   rx_phase;
    logic   acc;

    // input taken only while parsing, never during read-out
    assign rx_phase = (r_state != ST_EMIT_RD) && (r_state != ST_EMIT_LD);
    assign acc      = i_valid && rx_phase;
    assign o_stall  = !rx_phase;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START1;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_START1: begin
                if (acc && i_sts.is_start1) n_state = ST_START2;
            end
            ST_START2: begin
                if (acc) begin
                    if (i_sts.is_start2)      n_state = ST_ID1;
                    else if (i_sts.is_start1) n_state = ST_START2;
                    else                      n_state = ST_START1;
                end
            end
            ST_ID1: begin
                if (acc) n_state = ST_ID2;
            end
            ST_ID2: begin
                if (acc) n_state = ST_CHAN;
            end
            ST_CHAN: begin
                if (acc) begin
                    if (i_sts.chan_ok)        n_state = ST_LEN1;
                    else if (i_sts.is_start1) n_state = ST_START2;
                    else                      n_state = ST_START1;
                end
            end
            ST_LEN1: begin
                if (acc) n_state = ST_LEN2;
            end
            ST_LEN2: begin
                if (acc) begin
                    if (i_sts.len_ok)         n_state = i_sts.len_zero ? ST_CHK1 : ST_DATA;
                    else if (i_sts.is_start1) n_state = ST_START2;
                    else                      n_state = ST_START1;
                end
            end
            ST_DATA: begin
                if (acc && i_sts.data_done) n_state = ST_CHK1;
            end
            ST_CHK1: begin
                if (acc) n_state = ST_CHK2;
            end
            ST_CHK2: begin
                if (acc) begin
                    // read index is only cleared on this edge, so always start with a read
                    if (i_sts.check_good)     n_state = ST_EMIT_RD;
                    else if (i_sts.is_start1) n_state = ST_START2;
                    else                      n_state = ST_START1;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (i_sts.out_free) n_state = i_sts.emit_last ? ST_START1 : ST_EMIT_RD;
            end
            default: begin
                n_state = ST_START1;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_START1: begin
                if (acc && i_sts.is_start1) o_cmd.sum_op = SUM_ADD;
            end
            ST_START2: begin
                if (acc) begin
                    if (i_sts.is_start2) o_cmd.sum_op = SUM_ADD;
                    else                 o_cmd.sum_op = i_sts.is_start1 ? SUM_SEED : SUM_CLEAR;
                end
            end
            ST_ID1: begin
                if (acc) begin
                    o_cmd.load_id_hi = 1'b1;
                    o_cmd.sum_op     = SUM_ADD;
                end
            end
            ST_ID2: begin
                if (acc) begin
                    o_cmd.load_id_lo = 1'b1;
                    o_cmd.sum_op     = SUM_ADD;
                end
            end
            ST_CHAN: begin
                if (acc) begin
                    o_cmd.load_chan = 1'b1;
                    if (i_sts.chan_ok) o_cmd.sum_op = SUM_ADD;
                    else               o_cmd.sum_op = i_sts.is_start1 ? SUM_SEED : SUM_CLEAR;
                end
            end
            ST_LEN1: begin
                if (acc) begin
                    o_cmd.load_len_hi = 1'b1;
                    o_cmd.sum_op      = SUM_ADD;
                end
            end
            ST_LEN2: begin
                if (acc) begin
                    o_cmd.load_len_lo = 1'b1;
                    o_cmd.cnt_clear   = 1'b1;
                    if (i_sts.len_ok) o_cmd.sum_op = SUM_ADD;
                    else              o_cmd.sum_op = i_sts.is_start1 ? SUM_SEED : SUM_CLEAR;
                end
            end
            ST_DATA: begin
                if (acc) begin
                    o_cmd.store_byte = 1'b1;
                    o_cmd.sum_op     = SUM_ADD;
                end
            end
            ST_CHK1: begin
                if (acc) o_cmd.load_chk = 1'b1;
            end
            ST_CHK2: begin
                if (acc) begin
                    o_cmd.rd_clear = 1'b1;
                    if (i_sts.check_good) o_cmd.sum_op = SUM_CLEAR;
                    else o_cmd.sum_op = i_sts.is_start1 ? SUM_SEED : SUM_CLEAR;
                end
            end
            ST_EMIT_RD: begin
                o_cmd.rd_issue = 1'b1;
            end
            ST_EMIT_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.rd_next  = !i_sts.emit_last;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/frc_datapath.sv
// ----------------------------------------------------------------------------
// frc_datapath
// Field registers, the two mod-256 checksum accumulators, the payload
// buffer, limit registers and the result output register.
// ----------------------------------------------------------------------------
module frc_datapath #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_cfg_we,
    input  frc_pkg::t_cfg_reg i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  frc_pkg::t_dp_cmd  i_cmd,
    output frc_pkg::t_dp_sts  o_sts,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [15:0]       o_frame_id,
    output logic [7:0]        o_channel,
    output logic [5:0]        o_payload_length,
    output logic              o_has_payload,
    output logic [5:0]        o_byte_index,
    output logic [7:0]        o_payload_byte,
    output logic              o_last
);
    import frc_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam logic [6:0] CAP_MAX =
        (BUFFER_BYTES < 64) ? 7'(BUFFER_BYTES) : MAX_PAYLOAD;

    logic [6:0]       r_length_limit;
    logic [7:0]       r_channel_limit;
    logic [15:0]      r_id;
    logic [7:0]       r_chan;
    logic [7:0]       r_len_hi;
    logic [CNT_W-1:0] r_len;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_rd_idx;
    logic [7:0]       r_sum1;
    logic [7:0]       r_sum2;
    logic [7:0]       r_chk_hi;
    logic [7:0]       r_rd_data;
    logic             r_o_valid;
    logic [7:0]       mem [BUFFER_BYTES];

    logic [7:0]       n_sum1;
    logic [6:0]       cap;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] rd_inc;
    logic             empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_limit  <= MAX_PAYLOAD;
            r_channel_limit <= 8'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LENGTH_LIMIT:  r_length_limit  <= i_cfg_data[6:0];
                CFG_CHANNEL_LIMIT: r_channel_limit <= i_cfg_data;
                default:           r_length_limit  <= r_length_limit;
            endcase
        end
    end

    // checksum accumulators
    assign n_sum1 = r_sum1 + i_rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum1 <= '0;
            r_sum2 <= '0;
        end else begin
            case (i_cmd.sum_op)
                SUM_HOLD: begin
                    r_sum1 <= r_sum1;
                end
                SUM_CLEAR: begin
                    r_sum1 <= '0;
                    r_sum2 <= '0;
                end
                SUM_ADD: begin
                    r_sum1 <= n_sum1;
                    r_sum2 <= r_sum2 + n_sum1;
                end
                SUM_SEED: begin
                    r_sum1 <= i_rx_byte;
                    r_sum2 <= i_rx_byte;
                end
                default: begin
                    r_sum1 <= '0;
                    r_sum2 <= '0;
                end
            endcase
        end
    end

    // frame field registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_id_hi)  r_id[15:8] <= i_rx_byte;
        if (i_cmd.load_id_lo)  r_id[7:0]  <= i_rx_byte;
        if (i_cmd.load_chan)   r_chan     <= i_rx_byte;
        if (i_cmd.load_len_hi) r_len_hi   <= i_rx_byte;
        if (i_cmd.load_len_lo) r_len      <= i_rx_byte[CNT_W-1:0];
        if (i_cmd.load_chk)    r_chk_hi   <= i_rx_byte;
    end

    // payload write counter and read index
    assign cnt_inc = r_count + 1'b1;
    assign rd_inc  = r_rd_idx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_clear)       r_count <= '0;
        else if (i_cmd.store_byte) r_count <= cnt_inc;
        if (i_cmd.rd_clear)        r_rd_idx <= '0;
        else if (i_cmd.rd_next)    r_rd_idx <= rd_inc;
    end

    // payload buffer, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte) mem[AW'(r_count)] <= i_rx_byte;
        if (i_cmd.rd_issue)   r_rd_data <= mem[AW'(r_rd_idx)];
    end

    // length cap is the smallest of limit, buffer size and field range
    assign cap   = (r_length_limit < CAP_MAX) ? r_length_limit : CAP_MAX;
    assign empty = (r_len == '0);

    // status to the controller
    always_comb begin
        o_sts.is_start1  = (i_rx_byte == START_FIRST);
        o_sts.is_start2  = (i_rx_byte == START_SECOND);
        o_sts.chan_ok    = (i_rx_byte < r_channel_limit);
        o_sts.len_ok     = (r_len_hi == 8'd0) && ({1'b0, i_rx_byte} < {2'b00, cap});
        o_sts.len_zero   = (i_rx_byte == 8'd0);
        o_sts.data_done  = (cnt_inc == r_len);
        o_sts.check_good = (r_chk_hi == r_sum1) && (i_rx_byte == r_sum2);
        o_sts.emit_last  = empty || (rd_inc == r_len);
        o_sts.out_free   = !r_o_valid || !i_stall;
    end

    // result output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_frame_id       <= r_id;
            o_channel        <= r_chan;
            o_payload_length <= r_len;
            o_has_payload    <= !empty;
            o_byte_index     <= empty ? '0 : r_rd_idx;
            o_payload_byte   <= empty ? 8'd0 : r_rd_data;
            o_last           <= empty || (rd_inc == r_len);
        end
    end

    assign o_valid = r_o_valid;

endmodule

FILE: hw/rtl/frame_receiver_with_checksum.sv
// ----------------------------------------------------------------------------
// frame_receiver_with_checksum
// Serial frame receiver: finds start-marked frames in a byte stream, checks
// their two-byte running checksum and releases the payload of good frames.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: one received byte per item on i_rx_byte, i_valid/o_stall.
//   Bytes are taken one per cycle while a frame is being parsed.
//   Output channel: one result per payload byte (one result with
//   o_has_payload low for an empty frame), o_valid/i_stall, o_last on the
//   final result of the frame.
//   Config channel: i_cfg_valid/o_cfg_ready, index 0 length limit, index 1
//   channel limit; write only while the block is idle.
//   Read-out: after the second check byte is taken, each result passes
//   through a registered buffer read and then an output register load,
//   and o_stall stays high throughout read-out. An empty frame's single
//   result takes the same steps. Once the last result sits in the
//   output register, input bytes are taken again.
//   Receiver stall: the output register holds its result and read-out
//   pauses until it is taken.
//   Reset: parser returns to the start-byte search, sums clear, limits
//   return to 64 and 16; the payload buffer is not cleared.
// ----------------------------------------------------------------------------
module frame_receiver_with_checksum #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_rx_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [15:0]       o_frame_id,
    output logic [7:0]        o_channel,
    output logic [5:0]        o_payload_length,
    output logic              o_has_payload,
    output logic [5:0]        o_byte_index,
    output logic [7:0]        o_payload_byte,
    output logic              o_last,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  frc_pkg::t_cfg_reg i_cfg_index,
    input  logic [7:0]        i_cfg_data
);
    import frc_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // limits are plain registers, always writable
    assign o_cfg_ready = 1'b1;

    // controller
    frc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // datapath
    frc_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_frame_id       (o_frame_id),
        .o_channel        (o_channel),
        .o_payload_length (o_payload_length),
        .o_has_payload    (o_has_payload),
        .o_byte_index     (o_byte_index),
        .o_payload_byte   (o_payload_byte),
        .o_last           (o_last)
    );

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_valid || !i_stall))
        else $error("output register loaded while holding a stalled result");

    // payload buffer written only by an accepted byte
    a_store_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.store_byte |-> (i_valid && !o_stall))
        else $error("payload stored without an accepted item");

    // byte index stays inside the frame
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_has_payload) |-> (o_byte_index < o_payload_length))
        else $error("byte index beyond payload length");

    // an empty frame gives exactly one, final result
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_payload) |-> (o_last && o_payload_length == 6'd0))
        else $error("empty frame result not marked last");

endmodule
